[hw/rtl/soc_pkg.sv]
package soc_pkg;

   // Default sizing for the top-level parameters
   localparam int MAX_PATTERN_DEF = 8;
   localparam int POS_WIDTH_DEF   = 16;

   // Fixed field widths
   localparam int BYTE_W      = 8;
   localparam int PAT_BYTES_W = 64;
   localparam int PAT_LEN_W   = 4;
   localparam int CNT_W       = 16;
   localparam int START_W     = 16;
   localparam int PAT_IDX_W   = 3;

   // Configuration register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN   = 1'd1;

   localparam logic [PAT_LEN_W-1:0] PAT_LEN_RESET = 4'd1;
   localparam logic [CNT_W-1:0]     CNT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last_in;
   } req_type;

   typedef struct packed {
      logic               match_here;
      logic [CNT_W-1:0]   match_count;
      logic               first_found;
      logic [START_W-1:0] first_start;
      logic               last_out;
   } rsp_type;

endpackage

[hw/rtl/soc_match.sv]
module soc_match #(
   parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF,
   parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic [MAX_PATTERN*soc_pkg::BYTE_W-1:0] hist,
   input  logic [FILL_W-1:0]                      fill,
   input  logic [soc_pkg::PAT_BYTES_W-1:0]        pattern_bytes,
   input  logic [soc_pkg::PAT_LEN_W-1:0]          pattern_len,
   output logic [soc_pkg::PAT_LEN_W-1:0]          eff_len,
   output logic                                   hit
);

   localparam int CMP_W = (FILL_W > soc_pkg::PAT_LEN_W ? FILL_W : soc_pkg::PAT_LEN_W) + 1;

   logic [MAX_PATTERN-1:0]       byte_ok;
   logic [soc_pkg::PAT_LEN_W-1:0] pat_idx_full [MAX_PATTERN];
   logic                         fill_ok;

   // Clamp an oversized length to the window size
   always_comb begin
      if (pattern_len > soc_pkg::PAT_LEN_W'(MAX_PATTERN)) begin
         eff_len = soc_pkg::PAT_LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = pattern_len;
      end
   end

   // Byte k back from the newest must equal pattern character len-1-k
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pat_idx_full[k] = eff_len - soc_pkg::PAT_LEN_W'(k) - soc_pkg::PAT_LEN_W'(1);
         if (soc_pkg::PAT_LEN_W'(k) >= eff_len) begin
            byte_ok[k] = 1'b1;
         end else begin
            byte_ok[k] = hist[k*soc_pkg::BYTE_W +: soc_pkg::BYTE_W] ==
                         pattern_bytes[pat_idx_full[k][soc_pkg::PAT_IDX_W-1:0]
                                       * soc_pkg::BYTE_W +: soc_pkg::BYTE_W];
         end
      end
   end

   assign fill_ok = (CMP_W'(fill) + CMP_W'(1)) >= CMP_W'(eff_len);
   assign hit     = (eff_len != '0) && fill_ok && (&byte_ok);

endmodule

[hw/rtl/substring_occurrence_counter.sv]
// Substring occurrence counter.
// Text arrives one byte per transfer on the req_ channel (valid/ready); the
// req_last_in flag marks the final byte of a string. Every byte yields exactly
// one result on the rsp_ channel: whether a pattern occurrence ends at that
// byte, the saturating count of non-overlapping matches in the string, and
// the start index of the first match. Matches never overlap: a hit empties
// the byte history, so the leftmost occurrence wins.
// The pattern (up to MAX_PATTERN bytes, first character in the lowest byte)
// and its length are set through the csr_ write channel, index 0 for the
// bytes and index 1 for the length; write them only while no string is in
// flight. csr_ready is always high.
// Each byte passes the input register and then the result register.
// Throughput: one byte per cycle while the receiver keeps up; the window
// compare and the state update fit between the two registers. When the
// receiver stalls, the result register holds its transfer and the input
// register can still take one more byte, after which req_ready drops.
// Reset (synchronous, active high) empties both registers, clears the
// per-string state and sets the pattern to zero with length one.
module substring_occurrence_counter #(
   parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF,
   parameter int POS_WIDTH   = soc_pkg::POS_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  soc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output soc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [soc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [soc_pkg::PAT_BYTES_W-1:0]   csr_data
);

   localparam int HIST_W = MAX_PATTERN * soc_pkg::BYTE_W;
   localparam int FILL_W = $clog2(MAX_PATTERN + 1);
   localparam int WIDE_W = 32;

   // Configuration
   logic [soc_pkg::PAT_BYTES_W-1:0] pattern_bytes_ff;
   logic [soc_pkg::PAT_LEN_W-1:0]   pattern_len_ff;

   // Input stage
   logic             in_valid_ff, in_valid_in;
   soc_pkg::req_type in_data_ff;

   // Result stage
   logic             rsp_valid_ff, rsp_valid_in;
   soc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Per-string state; the window keeps the last byte slot unused since it
   // is shifted out before the next compare
   logic [HIST_W-1:0]        window_ff, window_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [soc_pkg::CNT_W-1:0] hit_count_ff, hit_count_in;
   logic [POS_WIDTH-1:0]     pos_ff, pos_in;
   logic                     seen_first_ff, seen_first_in;
   logic [POS_WIDTH-1:0]     first_index_ff, first_index_in;

   logic                          advance;
   logic                          step;
   logic [HIST_W-1:0]             hist;
   logic [soc_pkg::PAT_LEN_W-1:0] eff_len;
   logic                          hit;
   logic [WIDE_W-1:0]             first_wide;

   // Move the input byte forward whenever the result register is free or
   // being drained this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = advance && in_valid_ff;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // History plus the new byte, newest in the low byte
   assign hist = (window_ff << soc_pkg::BYTE_W) | HIST_W'(in_data_ff.text_byte);

   soc_match #(
      .MAX_PATTERN(MAX_PATTERN),
      .FILL_W     (FILL_W)
   ) u_match (
      .hist         (hist),
      .fill         (fill_ff),
      .pattern_bytes(pattern_bytes_ff),
      .pattern_len  (pattern_len_ff),
      .eff_len      (eff_len),
      .hit          (hit)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   // Next state for one byte
   always_comb begin
      window_in      = window_ff;
      fill_in        = fill_ff;
      hit_count_in   = hit_count_ff;
      pos_in         = pos_ff;
      seen_first_in  = seen_first_ff;
      first_index_in = first_index_ff;

      if (hit) begin
         // Drop the history so the next match cannot overlap this one
         window_in = '0;
         fill_in   = '0;
         if (hit_count_ff != soc_pkg::CNT_MAX) begin
            hit_count_in = hit_count_ff + soc_pkg::CNT_W'(1);
         end
         if (!seen_first_ff) begin
            seen_first_in  = 1'b1;
            first_index_in = pos_ff - POS_WIDTH'(eff_len) + POS_WIDTH'(1);
         end
      end else begin
         window_in = hist;
         if (fill_ff != FILL_W'(MAX_PATTERN - 1)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end

      // Hold the position once it saturates
      if (pos_ff != {POS_WIDTH{1'b1}}) begin
         pos_in = pos_ff + POS_WIDTH'(1);
      end
   end

   assign first_wide = WIDE_W'(first_index_in);

   always_comb begin
      rsp_data_in.match_here  = hit;
      rsp_data_in.match_count = hit_count_in;
      rsp_data_in.first_found = seen_first_in;
      rsp_data_in.first_start = seen_first_in ? first_wide[soc_pkg::START_W-1:0] : '0;
      rsp_data_in.last_out    = in_data_ff.last_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff <= '0;
         pattern_len_ff   <= soc_pkg::PAT_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            soc_pkg::CSR_PATTERN_BYTES: begin
               pattern_bytes_ff <= csr_data;
            end
            soc_pkg::CSR_PATTERN_LEN: begin
               pattern_len_ff <= csr_data[soc_pkg::PAT_LEN_W-1:0];
            end
            default: begin
               pattern_len_ff <= pattern_len_ff;
            end
         endcase
      end
   end

   // Handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Per-string state; the final byte of a string returns it to reset
   always_ff @(posedge clock) begin
      if (reset || (step && in_data_ff.last_in)) begin
         window_ff      <= '0;
         fill_ff        <= '0;
         hit_count_ff   <= '0;
         pos_ff         <= '0;
         seen_first_ff  <= 1'b0;
         first_index_ff <= '0;
      end else if (step) begin
         window_ff      <= window_in;
         fill_ff        <= fill_in;
         hit_count_ff   <= hit_count_in;
         pos_ff         <= pos_in;
         seen_first_ff  <= seen_first_in;
         first_index_ff <= first_index_in;
      end
   end

endmodule
